@@ hdl/necd_pkg.sv @@
// Shared types and constants for the NEC infrared command decoder.
`default_nettype none

package necd_pkg;

  localparam int TS_W      = 16;
  localparam int CMD_W     = 8;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX    = 3'd5;

  localparam logic [TS_W-1:0] LEADER_MIN_RST = 16'd13951;
  localparam logic [TS_W-1:0] LEADER_MAX_RST = 16'd14607;
  localparam logic [TS_W-1:0] ONE_MIN_RST    = 16'd2230;
  localparam logic [TS_W-1:0] ONE_MAX_RST    = 16'd2470;

  // Key codes.
  localparam logic [CMD_W-1:0] KEY_RED_SET     = 8'hBA;
  localparam logic [CMD_W-1:0] KEY_RED_CLEAR   = 8'hB9;
  localparam logic [CMD_W-1:0] KEY_RED_TOGGLE  = 8'hB8;
  localparam logic [CMD_W-1:0] KEY_GREEN_SET   = 8'hBB;
  localparam logic [CMD_W-1:0] KEY_GREEN_CLEAR = 8'hBF;
  localparam logic [CMD_W-1:0] KEY_GREEN_TOGGLE = 8'hBC;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEADER,
    PH_SYNC,
    PH_BITS
  } phase_t;

  // One classified edge as it travels from the front end to the back end.
  typedef struct packed {
    logic rising;
    logic leader_ok;
    logic one_ok;
  } edge_class_t;

endpackage

`default_nettype wire

@@ hdl/necd_front.sv @@
// Front end: holds the timing windows, times each edge and classifies it.
`default_nettype none

module necd_front (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_valid,
  input  wire  [necd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [necd_pkg::TS_W-1:0]         cfg_data,
  input  wire                               in_valid,
  input  wire                               in_rising,
  input  wire  [necd_pkg::TS_W-1:0]         in_timestamp,
  input  wire                               in_accept,
  output necd_pkg::edge_class_t             cls
);
  import necd_pkg::*;

  logic [TS_W-1:0] leader_min;
  logic [TS_W-1:0] leader_max;
  logic [TS_W-1:0] one_min;
  logic [TS_W-1:0] one_max;
  logic [TS_W-1:0] last_rise;
  logic [TS_W-1:0] last_fall;
  logic [TS_W-1:0] interval;

  // The zero window has no effect on decoding, so its writes are taken and dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      leader_min <= LEADER_MIN_RST;
      leader_max <= LEADER_MAX_RST;
      one_min    <= ONE_MIN_RST;
      one_max    <= ONE_MAX_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEADER_MIN: leader_min <= cfg_data;
        REG_LEADER_MAX: leader_max <= cfg_data;
        REG_ONE_MIN:    one_min    <= cfg_data;
        REG_ONE_MAX:    one_max    <= cfg_data;
        REG_ZERO_MIN, REG_ZERO_MAX: ;
        default: ;
      endcase
    end
  end

  // A leader always ends on the falling edge after the one that started it, and each
  // data interval ends on the rising edge after the one that started it, so the last
  // edge of the same polarity is always the start of the interval being timed.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_rise <= '0;
      last_fall <= '0;
    end else if (in_accept) begin
      if (in_rising) begin
        last_rise <= in_timestamp;
      end else begin
        last_fall <= in_timestamp;
      end
    end
  end

  assign interval = in_timestamp - (in_rising ? last_rise : last_fall);

  always_comb begin
    cls.rising    = in_rising & in_valid;
    cls.leader_ok = (interval > leader_min) && (interval < leader_max);
    cls.one_ok    = (interval > one_min) && (interval < one_max);
  end

endmodule

`default_nettype wire

@@ hdl/necd_queue.sv @@
// Short queue of classified edges between the front end and the back end.
`default_nettype none

module necd_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push_valid,
  output logic                   push_ready,
  input  wire necd_pkg::edge_class_t push_item,
  output logic                   pop_valid,
  input  wire                    pop_ready,
  output necd_pkg::edge_class_t  pop_item
);
  import necd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  edge_class_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != (PTR_W+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/necd_back.sv @@
// Back end: frame state machine, command shift register, LED actions and result register.
`default_nettype none

module necd_back #(
  parameter int FRAME_BITS = 32,
  parameter int KEEP_FROM  = 24
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             q_valid,
  output logic                            q_ready,
  input  wire necd_pkg::edge_class_t      q_item,
  output logic                            res_valid,
  input  wire                             res_ready,
  output logic [necd_pkg::CMD_W-1:0]      res_cmd,
  output logic                            res_red,
  output logic                            res_green
);
  import necd_pkg::*;

  localparam int IDX_W = $clog2(FRAME_BITS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

  phase_t           phase;
  phase_t           phase_next;
  logic [IDX_W-1:0] bit_index;
  logic [IDX_W-1:0] bit_index_next;
  logic [CMD_W-1:0] shift_byte;
  logic [CMD_W-1:0] shift_next;
  logic             red_level;
  logic             red_next;
  logic             green_level;
  logic             green_next;
  logic             pop;
  logic             emit;
  logic             keep_bit;
  logic             last_bit;

  assign q_ready  = !res_valid || res_ready;
  assign pop      = q_valid && q_ready;
  assign keep_bit = (32'(bit_index) >= 32'(KEEP_FROM));
  assign last_bit = (bit_index == LAST_IDX);

  always_comb begin
    phase_next = phase;
    if (pop) begin
      unique case (phase)
        PH_IDLE:   if (!q_item.rising) phase_next = PH_LEADER;
        PH_LEADER: if (!q_item.rising) phase_next = q_item.leader_ok ? PH_SYNC : PH_IDLE;
        PH_SYNC:   if (q_item.rising) phase_next = PH_BITS;
        PH_BITS:   if (q_item.rising && last_bit) phase_next = PH_IDLE;
        default:   phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    bit_index_next = bit_index;
    shift_next     = shift_byte;
    emit           = 1'b0;
    if (pop && q_item.rising) begin
      unique case (phase)
        PH_SYNC: begin
          bit_index_next = '0;
          shift_next     = '0;
        end
        PH_BITS: begin
          if (keep_bit) begin
            shift_next = {q_item.one_ok, shift_byte[CMD_W-1:1]};
          end
          if (last_bit) begin
            bit_index_next = '0;
            emit           = 1'b1;
          end else begin
            bit_index_next = bit_index + IDX_W'(1);
          end
        end
        PH_IDLE, PH_LEADER: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    red_next   = red_level;
    green_next = green_level;
    if (emit) begin
      unique case (shift_next)
        KEY_RED_SET:      red_next   = 1'b1;
        KEY_RED_CLEAR:    red_next   = 1'b0;
        KEY_RED_TOGGLE:   red_next   = !red_level;
        KEY_GREEN_SET:    green_next = 1'b1;
        KEY_GREEN_CLEAR:  green_next = 1'b0;
        KEY_GREEN_TOGGLE: green_next = !green_level;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_index   <= '0;
      shift_byte  <= '0;
      red_level   <= 1'b0;
      green_level <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      bit_index   <= bit_index_next;
      shift_byte  <= shift_next;
      red_level   <= red_next;
      green_level <= green_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_cmd   <= shift_next;
      res_red   <= red_next;
      res_green <= green_next;
    end
  end

`ifndef SYNTHESIS
  a_index_idle: assert property (@(posedge clk) disable iff (rst)
    phase != PH_BITS |-> bit_index == '0)
    else $error("bit index nonzero outside the data phase");

  a_sync_clears: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SYNC && pop && q_item.rising) |=>
      (phase == PH_BITS && bit_index == '0 && shift_byte == '0))
    else $error("sync edge did not start a clean frame");

  a_emit_result: assert property (@(posedge clk) disable iff (rst)
    emit |=> (res_valid && res_cmd == $past(shift_next) && phase == PH_IDLE))
    else $error("completed frame did not load the result register");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !pop)
    else $error("edge consumed while a result is stalled");
`endif

endmodule

`default_nettype wire

@@ hdl/nec_ir_command_decoder.sv @@
// Result path: the frame's final edge is written into the edge queue, and m_tvalid rises once
// the back end pops that edge and loads the result register.
// Throughput: one edge per cycle unless stalled; the back end consumes one queued edge per
// cycle unless the result register is stalled, and the four-entry queue absorbs short stalls.
// Reset (rst, synchronous): windows return to their defaults, the frame state goes idle,
// both LEDs turn off and the edge queue and result register empty.
`default_nettype none

module nec_ir_command_decoder #(
  parameter int FRAME_BITS = 32,
  parameter int KEEP_FROM  = 24
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [necd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [necd_pkg::TS_W-1:0]        cfg_data,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire  [15:0]                      s_tdata,   // [15:0] timestamp
  input  wire                              s_tuser,   // [0] edge_rising
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [15:0]                      m_tdata    // [7:0] command_byte, [8] led_red,
                                                      // [9] led_green, [15:10] zero
);
  import necd_pkg::*;

  edge_class_t      front_cls;
  edge_class_t      q_item;
  logic             q_valid;
  logic             q_ready;
  logic             push_ready;
  logic [CMD_W-1:0] res_cmd;
  logic             res_red;
  logic             res_green;

  assign cfg_ready = 1'b1;
  assign s_tready  = push_ready;

  necd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (s_tvalid),
    .in_rising    (s_tuser),
    .in_timestamp (s_tdata),
    .in_accept    (s_tvalid && push_ready),
    .cls          (front_cls)
  );

  necd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (push_ready),
    .push_item  (front_cls),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  necd_back #(
    .FRAME_BITS (FRAME_BITS),
    .KEEP_FROM  (KEEP_FROM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_cmd   (res_cmd),
    .res_red   (res_red),
    .res_green (res_green)
  );

  assign m_tdata = {6'b0, res_green, res_red, res_cmd};

endmodule

`default_nettype wire

@@ sim/tb_nec_ir_command_decoder.sv @@
// Self-checking testbench for the NEC infrared command decoder: frame stimulus, prediction, checks.
`default_nettype none

module tb_nec_ir_command_decoder;
  import necd_pkg::*;

  localparam int FRAME_BITS = 32;
  localparam int KEEP_FROM  = 24;
  localparam logic [TS_W-1:0] ZERO_MIN_RST = 16'd1120;
  localparam logic [TS_W-1:0] ZERO_MAX_RST = 16'd1320;
  localparam logic [CMD_W-1:0] KEY_CODES [0:5] = '{KEY_RED_SET, KEY_RED_CLEAR, KEY_RED_TOGGLE,
                                                   KEY_GREEN_SET, KEY_GREEN_CLEAR,
                                                   KEY_GREEN_TOGGLE};

  typedef struct packed {
    logic            rising;
    logic [TS_W-1:0] ts;
  } ir_edge_t;

  typedef struct packed {
    logic [5:0]       pad;
    logic             green;
    logic             red;
    logic [CMD_W-1:0] cmd;
  } key_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TS_W-1:0]      cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [15:0]          m_tdata;

  nec_ir_command_decoder #(
    .FRAME_BITS(FRAME_BITS),
    .KEEP_FROM (KEEP_FROM)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder shadow: windows, frame state and LED levels.
  logic [TS_W-1:0]  win_lim [0:5];
  phase_t           frame_ph;
  logic [TS_W-1:0]  frame_t0;
  int               bit_cnt;
  logic [CMD_W-1:0] cmd_acc;
  logic             red_on;
  logic             green_on;

  ir_edge_t    edge_q [$];
  key_result_t key_result_q [$];
  ir_edge_t    next_edge;
  key_result_t got, want;
  logic [TS_W-1:0] gen_ts = '0;
  int  n_queued    = 0;
  int  n_accepted  = 0;
  int  n_errors    = 0;
  int  src_idle_pct  = 7;
  int  sink_idle_pct = 78;
  logic s_taken = 1'b0;

  function automatic logic in_window(input logic [TS_W-1:0] v, lo, hi);
    return (v > lo) && (v < hi);
  endfunction

  task automatic decode_edge(input logic rising, input logic [TS_W-1:0] ts);
    logic [TS_W-1:0] span;
    key_result_t r;
    span = ts - frame_t0;
    case (frame_ph)
      PH_LEADER: begin
        if (!rising)
          frame_ph = in_window(span, win_lim[REG_LEADER_MIN], win_lim[REG_LEADER_MAX]) ?
                     PH_SYNC : PH_IDLE;
      end
      PH_SYNC: begin
        if (rising) begin
          frame_t0 = ts;
          bit_cnt  = 0;
          cmd_acc  = '0;
          frame_ph = PH_BITS;
        end
      end
      PH_BITS: begin
        if (rising) begin
          frame_t0 = ts;
          if (bit_cnt >= KEEP_FROM)
            cmd_acc = {in_window(span, win_lim[REG_ONE_MIN], win_lim[REG_ONE_MAX]),
                       cmd_acc[7:1]};
          if (bit_cnt + 1 >= FRAME_BITS) begin
            case (cmd_acc)
              KEY_RED_SET:      red_on   = 1'b1;
              KEY_RED_CLEAR:    red_on   = 1'b0;
              KEY_RED_TOGGLE:   red_on   = ~red_on;
              KEY_GREEN_SET:    green_on = 1'b1;
              KEY_GREEN_CLEAR:  green_on = 1'b0;
              KEY_GREEN_TOGGLE: green_on = ~green_on;
              default: ;
            endcase
            frame_ph = PH_IDLE;
            bit_cnt  = 0;
            r = '{pad: '0, green: green_on, red: red_on, cmd: cmd_acc};
            key_result_q.push_back(r);
          end else begin
            bit_cnt = bit_cnt + 1;
          end
        end
      end
      default: begin
        frame_ph = PH_IDLE;
        if (!rising) begin
          frame_t0 = ts;
          frame_ph = PH_LEADER;
        end
      end
    endcase
  endtask

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10)
      $display("%0t: %s", $time, msg);
  endtask

  // Monitor: predicts on each input transfer, checks each output transfer.
  always @(posedge clk) begin
    if (rst) begin
      s_taken <= 1'b0;
    end else begin
      s_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        n_accepted++;
        decode_edge(s_tuser, s_tdata);
      end
      if (m_tvalid && m_tready) begin
        got = key_result_t'(m_tdata);
        if (key_result_q.size() == 0) begin
          flag_error($sformatf("unexpected result cmd=%h red=%b green=%b",
                               got.cmd, got.red, got.green));
        end else begin
          want = key_result_q.pop_front();
          if (got.cmd !== want.cmd || got.red !== want.red || got.green !== want.green ||
              got.pad !== want.pad)
            flag_error($sformatf("result mismatch: expected cmd=%h red=%b green=%b pad=%h, got cmd=%h red=%b green=%b pad=%h",
                                 want.cmd, want.red, want.green, want.pad,
                                 got.cmd, got.red, got.green, got.pad));
        end
      end
    end
  end

  // Driver: edges from the pending queue, random gaps on both sides.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    if (!s_tvalid || s_taken) begin
      if (edge_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        next_edge = edge_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= next_edge.rising;
        s_tdata  <= next_edge.ts;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  task automatic add_edge(input logic rising, input logic [TS_W-1:0] ts);
    edge_q.push_back('{rising: rising, ts: ts});
    n_queued++;
  endtask

  // Mostly strictly inside the window, sometimes on a bound.
  function automatic logic [TS_W-1:0] pick_in(input logic [TS_W-1:0] lo, hi);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)
      return lo;
    if (r == 1)
      return hi;
    if (int'(hi) > int'(lo) + 1)
      return TS_W'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    return TS_W'($urandom);
  endfunction

  // One frame; a fault is one of: bad leader, random bit timing, truncation, wrong-polarity noise.
  task automatic queue_frame(input logic [CMD_W-1:0] cmd, input bit broken);
    logic [TS_W-1:0] gap;
    int fault, last_bit, k;
    logic one;
    fault    = broken ? $urandom_range(1, 4) : 0;
    last_bit = (fault == 3) ? $urandom_range(0, FRAME_BITS - 2) : FRAME_BITS - 1;
    gen_ts = gen_ts + TS_W'($urandom_range(1, 65535));
    add_edge(1'b0, gen_ts);
    gap = (fault == 1) ? TS_W'($urandom) : pick_in(win_lim[REG_LEADER_MIN],
                                                    win_lim[REG_LEADER_MAX]);
    if (fault == 4)
      add_edge(1'b1, gen_ts + gap / 2);
    gen_ts = gen_ts + gap;
    add_edge(1'b0, gen_ts);
    if (fault == 4)
      add_edge(1'b0, gen_ts + 16'd300);
    gen_ts = gen_ts + TS_W'($urandom_range(400, 700));
    add_edge(1'b1, gen_ts);
    for (k = 0; k <= last_bit; k++) begin
      one = (k >= KEEP_FROM) ? cmd[k - KEEP_FROM] : 1'($urandom);
      gap = one ? pick_in(win_lim[REG_ONE_MIN], win_lim[REG_ONE_MAX]) :
                  pick_in(win_lim[REG_ZERO_MIN], win_lim[REG_ZERO_MAX]);
      if (fault == 2 && $urandom_range(0, 3) == 0)
        gap = TS_W'($urandom);
      // Falling edges inside a bit are ignored by the decoder.
      if ($urandom_range(0, 3) == 0)
        add_edge(1'b0, gen_ts + gap / 2);
      gen_ts = gen_ts + gap;
      add_edge(1'b1, gen_ts);
    end
  endtask

  task automatic run_random(input int n_items);
    int stop_at, frame_no;
    logic [CMD_W-1:0] cmd;
    stop_at  = n_queued + n_items;
    frame_no = 0;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 3)) add_edge(1'($urandom), TS_W'($urandom));
      end else begin
        if (frame_no < 6)
          cmd = KEY_CODES[frame_no];
        else if ($urandom_range(0, 9) < 6)
          cmd = KEY_CODES[$urandom_range(0, 5)];
        else
          cmd = CMD_W'($urandom);
        frame_no++;
        queue_frame(cmd, $urandom_range(0, 99) < 15);
      end
    end
  endtask

  // The sender holds off until every edge is taken and every result has come back.
  task automatic wait_drained();
    while (n_accepted != n_queued) @(negedge clk);
    while (key_result_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TS_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    win_lim[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_windows(input logic [TS_W-1:0] lmin, lmax, zmin, zmax, omin, omax);
    write_reg(REG_LEADER_MIN, lmin);
    write_reg(REG_LEADER_MAX, lmax);
    write_reg(REG_ZERO_MIN, zmin);
    write_reg(REG_ZERO_MAX, zmax);
    write_reg(REG_ONE_MIN, omin);
    write_reg(REG_ONE_MAX, omax);
  endtask

  initial begin
    win_lim[REG_LEADER_MIN] = LEADER_MIN_RST;
    win_lim[REG_LEADER_MAX] = LEADER_MAX_RST;
    win_lim[REG_ZERO_MIN]   = ZERO_MIN_RST;
    win_lim[REG_ZERO_MAX]   = ZERO_MAX_RST;
    win_lim[REG_ONE_MIN]    = ONE_MIN_RST;
    win_lim[REG_ONE_MAX]    = ONE_MAX_RST;
    frame_ph = PH_IDLE;
    frame_t0 = '0;
    bit_cnt  = 0;
    cmd_acc  = '0;
    red_on   = 1'b0;
    green_on = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed edges with the reset windows.
    add_edge(1'b1, 16'hFFFF);                    // rising while idle is ignored
    add_edge(1'b0, 16'h0000);
    add_edge(1'b1, 16'd100);                     // rising during the leader is ignored
    // A leader equal to the upper bound fails, and its closing edge opens nothing.
    add_edge(1'b0, LEADER_MAX_RST);
    add_edge(1'b0, 16'd20000);
    add_edge(1'b0, 16'd20000 + LEADER_MIN_RST);  // equal to the lower bound also fails
    queue_frame(KEY_RED_TOGGLE, 1'b0);
    wait_drained();

    src_idle_pct  = 7;
    sink_idle_pct = 78;
    load_windows(16'd1000, 16'd60000, 16'd100, 16'd300, 16'd400, 16'd900);
    run_random(450);
    wait_drained();

    src_idle_pct  = 78;
    sink_idle_pct = 7;
    load_windows(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    run_random(450);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    load_windows(LEADER_MIN_RST, LEADER_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
                 ONE_MIN_RST, ONE_MAX_RST);
    run_random(500);
    wait_drained();

    // Inverted windows: nothing can pass the leader.
    load_windows(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    run_random(150);
    wait_drained();

    if (n_errors == 0 && key_result_q.size() == 0)
      $display("PASS nec_ir_command_decoder");
    else
      $display("FAIL nec_ir_command_decoder");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL nec_ir_command_decoder");
    $finish;
  end

endmodule

`default_nettype wire
